[design/yuv2rgb_pkg.sv]
// Shared types, fixed-point constants and the channel clamp for the YUYV to RGB converter.
package yuv2rgb_pkg;

   localparam int SAMPLE_W = 8;
   localparam int DELTA_W  = SAMPLE_W + 1;
   localparam int COEF_W   = 18;
   localparam int PROD_W   = 25;
   localparam int ACC_W    = 26;
   localparam int FRAC_W   = 16;
   localparam int WHOLE_W  = ACC_W - FRAC_W;

   localparam logic signed [COEF_W-1:0] COEF_R_V = 18'sd89832;
   localparam logic signed [COEF_W-1:0] COEF_G_V = 18'sd45745;
   localparam logic signed [COEF_W-1:0] COEF_G_U = 18'sd22127;
   localparam logic signed [COEF_W-1:0] COEF_B_U = 18'sd113537;

   localparam logic signed [DELTA_W-1:0] CHROMA_MID = 9'sd128;
   localparam logic signed [WHOLE_W-1:0] CHAN_MAX   = 10'sd255;

   // Chroma products shared by both pixels of a macropixel.
   typedef struct packed {
      logic signed [PROD_W-1:0] red_v;
      logic signed [PROD_W-1:0] green_v;
      logic signed [PROD_W-1:0] green_u;
      logic signed [PROD_W-1:0] blue_u;
   } prod_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] blue;
      logic [SAMPLE_W-1:0] green;
      logic [SAMPLE_W-1:0] red;
   } rgb_type;

   // Load strobes for the sum stage and the output stage.
   typedef struct packed {
      logic load_sum;
      logic load_out;
   } stage_en_type;

   function automatic logic signed [DELTA_W-1:0] center(input logic [SAMPLE_W-1:0] raw);
      logic signed [DELTA_W-1:0] ext;
      ext = signed'({1'b0, raw});
      return ext - CHROMA_MID;
   endfunction

   function automatic logic signed [PROD_W-1:0] mul_coef(input logic signed [DELTA_W-1:0] d,
                                                         input logic signed [COEF_W-1:0] c);
      logic signed [DELTA_W+COEF_W-1:0] full;
      full = d * c;
      return full[PROD_W-1:0];
   endfunction

   // Floor by the arithmetic shift, then saturate to 0..255.
   function automatic logic [SAMPLE_W-1:0] clamp_channel(input logic signed [ACC_W-1:0] acc);
      logic signed [WHOLE_W-1:0] whole;
      logic [SAMPLE_W-1:0]       res;
      whole = acc[ACC_W-1:FRAC_W];
      if (whole < 0) begin
         res = '0;
      end else if (whole > CHAN_MAX) begin
         res = '1;
      end else begin
         res = whole[SAMPLE_W-1:0];
      end
      return res;
   endfunction

endpackage

[design/yuv2rgb_pixel.sv]
// Sum and clamp stages for one pixel of the pair.
module yuv2rgb_pixel
   import yuv2rgb_pkg::*;
(
   input  logic                clock,
   input  stage_en_type        en,
   input  logic [SAMPLE_W-1:0] luma,
   input  prod_type            prod,
   output rgb_type             pix
);

   logic signed [ACC_W-1:0] base;
   logic signed [ACC_W-1:0] red_in, green_in, blue_in;
   logic signed [ACC_W-1:0] red_ff, green_ff, blue_ff;
   rgb_type                 pix_in, pix_ff;

   always_comb begin
      base     = signed'({2'b00, luma, {FRAC_W{1'b0}}});
      red_in   = base + ACC_W'(prod.red_v);
      green_in = base - ACC_W'(prod.green_v) - ACC_W'(prod.green_u);
      blue_in  = base + ACC_W'(prod.blue_u);
      pix_in.red   = clamp_channel(red_ff);
      pix_in.green = clamp_channel(green_ff);
      pix_in.blue  = clamp_channel(blue_ff);
   end

   always_ff @(posedge clock) begin
      if (en.load_sum) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
      if (en.load_out) begin
         pix_ff <= pix_in;
      end
   end

   assign pix = pix_ff;

endmodule

[design/yuyv_to_rgb_converter.sv]
// Top level of the YUYV macropixel to dual RGB pixel converter.
//
// Each input word carries one YUYV macropixel and each output word carries the two RGB
// pixels it decodes to, using BT.601-style Q16 coefficients with every channel floored
// and saturated to 0..255. The block is a three-stage pipeline: the first stage forms
// the four chroma products shared by both pixels, the second adds them to the scaled
// luma of each pixel, and the third shifts, clamps and holds the result in the output
// register. It takes one word per clock when the result side keeps up. A word accepted
// into the product registers moves through the sum registers and then the output register
// before it is shown. Each stage has its own valid bit and loads whenever it is empty
// or its contents move on, so back-pressure from the result side fills the empty stages
// first and loses or repeats no word. There are no configuration registers and no state
// beyond the pipeline itself.
module yuyv_to_rgb_converter
   import yuv2rgb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // From bit 0: luma_first, chroma_blue, luma_second, chroma_red (8 bits each).
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // From bit 0: red_first, green_first, blue_first, red_second, green_second,
   // blue_second (8 bits each).
   output logic [47:0] rsp_tdata
);

   // Valid bits of the product, sum and output stages.
   logic prod_vld_ff, sum_vld_ff, out_vld_ff;
   logic prod_vld_in, sum_vld_in, out_vld_in;
   logic prod_rdy, sum_rdy, out_rdy;

   logic [SAMPLE_W-1:0] luma0_ff, luma1_ff;
   prod_type            prod_in, prod_ff;
   stage_en_type        en;
   rgb_type             pix0, pix1;

   logic signed [DELTA_W-1:0] du, dv;

   // A stage can load when it is empty or when its word leaves this cycle.
   assign out_rdy    = !out_vld_ff || rsp_tready;
   assign sum_rdy    = !sum_vld_ff || out_rdy;
   assign prod_rdy   = !prod_vld_ff || sum_rdy;
   assign req_tready = prod_rdy;

   assign en.load_sum = sum_rdy;
   assign en.load_out = out_rdy;

   always_comb begin
      du = center(req_tdata[15:8]);
      dv = center(req_tdata[31:24]);
      prod_in.red_v   = mul_coef(dv, COEF_R_V);
      prod_in.green_v = mul_coef(dv, COEF_G_V);
      prod_in.green_u = mul_coef(du, COEF_G_U);
      prod_in.blue_u  = mul_coef(du, COEF_B_U);

      prod_vld_in = prod_rdy ? req_tvalid : prod_vld_ff;
      sum_vld_in  = sum_rdy ? prod_vld_ff : sum_vld_ff;
      out_vld_in  = out_rdy ? sum_vld_ff : out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         sum_vld_ff  <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         prod_vld_ff <= prod_vld_in;
         sum_vld_ff  <= sum_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   // Payload registers; luma rides alongside the products into the sum stage.
   always_ff @(posedge clock) begin
      if (prod_rdy) begin
         prod_ff  <= prod_in;
         luma0_ff <= req_tdata[7:0];
         luma1_ff <= req_tdata[23:16];
      end
   end

   yuv2rgb_pixel u_pixel_first (
      .clock (clock),
      .en    (en),
      .luma  (luma0_ff),
      .prod  (prod_ff),
      .pix   (pix0)
   );

   yuv2rgb_pixel u_pixel_second (
      .clock (clock),
      .en    (en),
      .luma  (luma1_ff),
      .prod  (prod_ff),
      .pix   (pix1)
   );

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {pix1.blue, pix1.green, pix1.red, pix0.blue, pix0.green, pix0.red};

endmodule

[design/yuv2rgb_checker.sv]
// Port-level checks for the YUYV to RGB converter, bound to the top level.
module yuv2rgb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   // A word offered on the result side stays until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word dropped or changed while stalled");

   // Reset empties the pipeline.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word shown right after reset");

   // With the result side taking words, the input side never stalls.
   assert property (@(posedge clock) disable iff (reset) rsp_tready |-> req_tready)
      else $error("input stalled although the output drains");

   // An accepted word reaches the output when nothing stalls.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 rsp_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("accepted word did not arrive at the output in time");

endmodule

bind yuyv_to_rgb_converter yuv2rgb_checker u_yuv2rgb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[tb/yuyv_to_rgb_converter_test.sv]
// Self-checking testbench for the YUYV macropixel to dual RGB pixel converter.
`timescale 1ns / 1ps

module yuyv_to_rgb_converter_test;

   // Scoreboard: predicts the two RGB pixels of every accepted macropixel and
   // checks each output word against the oldest prediction.
   class pixel_scoreboard;
      logic [47:0] pending_pixels[$];
      int          mismatches = 0;

      // Floor of the Q16 sum by an arithmetic shift, then saturate to 0..255.
      function logic [7:0] to_channel(int acc);
         int whole;
         whole = acc >>> 16;
         if (whole < 0) begin
            return 8'd0;
         end else if (whole > 255) begin
            return 8'd255;
         end
         return whole[7:0];
      endfunction

      function logic [23:0] convert_pixel(logic [7:0] luma, int du, int dv);
         int base;
         logic [7:0] red, green, blue;
         base  = int'(luma) * 65536;
         red   = to_channel(base + 89832 * dv);
         green = to_channel(base - 45745 * dv - 22127 * du);
         blue  = to_channel(base + 113537 * du);
         return {blue, green, red};
      endfunction

      function logic [47:0] convert_macropixel(logic [31:0] word);
         int du, dv;
         du = int'(word[15:8]) - 128;
         dv = int'(word[31:24]) - 128;
         return {convert_pixel(word[23:16], du, dv), convert_pixel(word[7:0], du, dv)};
      endfunction

      function string field_name(int index);
         case (index)
            0: return "red_first";
            1: return "green_first";
            2: return "blue_first";
            3: return "red_second";
            4: return "green_second";
            default: return "blue_second";
         endcase
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      function void note_macropixel(logic [31:0] word);
         pending_pixels.push_back(convert_macropixel(word));
      endfunction

      task check_pixel_pair(logic [47:0] got);
         logic [47:0] want;
         if (pending_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h", got));
         end else begin
            want = pending_pixels.pop_front();
            for (int i = 0; i < 6; i++) begin
               if (got[8*i +: 8] !== want[8*i +: 8]) begin
                  report_mismatch($sformatf("%s got %0d expected %0d", field_name(i),
                                            got[8*i +: 8], want[8*i +: 8]));
               end
            end
         end
      endtask

      function int outstanding();
         return pending_pixels.size();
      endfunction
   endclass

   localparam int RANDOM_WORDS = 1000;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 200000;
   // The pipeline is three stages deep; a few extra cycles catch stray words.
   localparam int SETTLE_CYCLES = 12;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // From bit 0: luma_first, chroma_blue, luma_second, chroma_red (8 bits each).
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // From bit 0: red_first, green_first, blue_first, red_second, green_second,
   // blue_second (8 bits each).
   logic [47:0] rsp_tdata;

   pixel_scoreboard scoreboard = new();

   // Long hold-off of the result side, requested by the stimulus process and
   // counted down by the receiver process.
   logic hold_request = 1'b0;
   bit   hold_done    = 1'b0;
   int   hold_left    = 0;
   int   stall_mode   = 0;
   int   cycle_count  = 0;

   yuyv_to_rgb_converter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Cycle counter with a generous timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycle_count);
         $display("yuyv_to_rgb_converter_test: FAIL");
         $finish;
      end
   end

   // Receiver. Every word taken at an edge is checked, and the ready for the next
   // cycle is chosen from a stall pattern that is redrawn at random: always ready,
   // half the time, mostly ready, or mostly stalled. The long hold-off overrides
   // the pattern while it lasts.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         scoreboard.check_pixel_pair(rsp_tdata);
      end
      if (cycle_count % 64 == 0) begin
         stall_mode = $urandom_range(0, 3);
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_request && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= $urandom_range(0, 1);
            2: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Offer one word and hold it until the block takes it. The valid stays high
   // when the caller sends the next word right away.
   task send_word(input logic [31:0] word);
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do begin
         @(posedge clock);
      end while (!req_tready);
      scoreboard.note_macropixel(word);
   endtask

   task idle_cycles(input int count);
      req_tvalid <= 1'b0;
      repeat (count) @(posedge clock);
   endtask

   // Stop sending until every predicted word has come out.
   task drain_pipeline();
      req_tvalid <= 1'b0;
      while (scoreboard.outstanding() != 0) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   // Mostly uniform macropixels; the rest push chroma toward its extremes so that
   // channels clamp at both ends more often.
   function logic [31:0] random_macropixel();
      logic [7:0] cb, cr;
      if ($urandom_range(0, 9) < 7) begin
         return $urandom;
      end
      cb = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(240, 255));
      cr = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(240, 255));
      return {cr, 8'($urandom_range(0, 255)), cb, 8'($urandom_range(0, 255))};
   endfunction

   logic [31:0] directed_words[] = '{
      32'h0000_0000,  // black with minimum chroma: red and blue clamp low
      32'hFFFF_FFFF,  // white with maximum chroma: red and blue clamp high
      32'h8000_8000,  // neutral chroma, black pixels
      32'h80FF_80FF,  // neutral chroma, white pixels
      32'h807F_8000,  // neutral chroma, black then mid gray
      32'hFF00_00FF,  // maximum Cr, minimum Cb
      32'h00FF_FF00,  // minimum Cr, maximum Cb
      32'h00FF_00FF,  // both chroma minimum, white luma: green clamps high
      32'hFF00_FF00,  // both chroma maximum, black luma: green clamps low
      32'hAAAA_AAAA,
      32'h5555_5555,
      32'h8080_8080,
      32'h7F7F_7F7F,
      32'h807F_807F,  // neutral chroma, luma just below mid gray
      32'h8181_8181,  // chroma just above its midpoint
      32'hFF80_FF80,
      32'h0080_0080,
      32'h80F0_8010
   };

   initial begin
      int sent;
      int burst;
      int gap;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_words[i]) begin
         send_word(directed_words[i]);
      end
      drain_pipeline();

      // Back-to-back words against a long result stall, so the pipeline fills
      // and the input side has to stall.
      hold_request <= 1'b1;
      for (int i = 0; i < 40; i++) begin
         send_word(random_macropixel());
      end
      sent = 40;

      while (sent < RANDOM_WORDS) begin
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && sent < RANDOM_WORDS; i++) begin
            send_word(random_macropixel());
            sent++;
            if (sent == RANDOM_WORDS / 2) begin
               drain_pipeline();
            end
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            idle_cycles(gap);
         end
      end

      drain_pipeline();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (scoreboard.mismatches == 0 && scoreboard.outstanding() == 0) begin
         $display("yuyv_to_rgb_converter_test: PASS");
      end else begin
         $display("yuyv_to_rgb_converter_test: FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
design/yuv2rgb_pkg.sv
design/yuv2rgb_pixel.sv
design/yuyv_to_rgb_converter.sv
design/yuv2rgb_checker.sv
tb/yuyv_to_rgb_converter_test.sv
